// ----- rtl/core/periodic_timer_bank_assert.svh -----
// Assertion macros used by the timer bank top level.
// Each property is sampled on the rising edge of clk and disabled while rst_n is low.
`ifndef PERIODIC_TIMER_BANK_ASSERT_SVH
`define PERIODIC_TIMER_BANK_ASSERT_SVH

`ifndef SYNTHESIS

`define PTB_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer bank assertion failed");

`define PTB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer bank assertion failed");

`else

`define PTB_ASSERT_SAME(lbl, ante, cons)

`define PTB_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/core/ptb_pkg.sv -----
package ptb_pkg;

    localparam int NUM_SLOTS_DEF = 8;
    localparam int KIND_W        = 3;
    localparam int SLOT_W        = 3;
    localparam int DATA_W        = 25;
    localparam int TICK_W        = 10;
    localparam int MASK_W        = 8;
    localparam int MASK_IDX_W    = $clog2(MASK_W);
    localparam int SLOT_CMP_W    = 7;

    localparam logic signed [DATA_W-1:0] VAL_MIN           = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] REMAINING_MISSING = '1;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK        = 3'd0,
        KIND_CREATE      = 3'd1,
        KIND_REMOVE      = 3'd2,
        KIND_SET_RESTART = 3'd3,
        KIND_SET_KEEP    = 3'd4,
        KIND_READ        = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SLOT,
        ST_TICK,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic slot_op;
        logic tick_issue;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic last_idx;
        logic out_free;
    } status_t;

endpackage

// ----- rtl/core/ptb_ctrl.sv -----
module ptb_ctrl
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic [ptb_pkg::KIND_W-1:0]      kind,
    output logic                            in_stall,
    input  ptb_pkg::status_t                status,
    output ptb_pkg::cmd_t                   cmd
);

    ptb_pkg::state_t state_reg;
    ptb_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ptb_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (ptb_pkg::kind_t'(kind) == ptb_pkg::KIND_TICK)
                    begin
                        state_next = ptb_pkg::ST_TICK;
                    end
                    else
                    begin
                        state_next = ptb_pkg::ST_SLOT;
                    end
                end
            end
            ptb_pkg::ST_SLOT:
            begin
                state_next = ptb_pkg::ST_FINISH;
            end
            ptb_pkg::ST_TICK:
            begin
                if (status.last_idx)
                begin
                    state_next = ptb_pkg::ST_DRAIN;
                end
            end
            ptb_pkg::ST_DRAIN:
            begin
                state_next = ptb_pkg::ST_FINISH;
            end
            ptb_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ptb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ptb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ptb_pkg::ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            ptb_pkg::ST_SLOT:
            begin
                cmd.slot_op = 1'b1;
            end
            ptb_pkg::ST_TICK:
            begin
                cmd.tick_issue = 1'b1;
            end
            ptb_pkg::ST_FINISH:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/core/ptb_datapath.sv -----
module ptb_datapath
#(
    parameter int NUM_SLOTS = ptb_pkg::NUM_SLOTS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  ptb_pkg::cmd_t                       cmd,
    output ptb_pkg::status_t                    status,
    input  logic [ptb_pkg::KIND_W-1:0]          kind,
    input  logic [ptb_pkg::SLOT_W-1:0]          slot,
    input  logic signed [ptb_pkg::DATA_W-1:0]   period,
    input  logic [ptb_pkg::TICK_W-1:0]          tick_cycles,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ptb_pkg::MASK_W-1:0]          fired_mask,
    output logic signed [ptb_pkg::DATA_W-1:0]   remaining,
    output logic                                missing_slot
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [ptb_pkg::SLOT_CMP_W-1:0] SLOT_LIMIT = ptb_pkg::SLOT_CMP_W'(NUM_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);
    localparam int DW = ptb_pkg::DATA_W;

    // latched transaction
    ptb_pkg::kind_t                 kind_reg;
    logic [ptb_pkg::SLOT_W-1:0]     slot_reg;
    logic signed [DW-1:0]           period_reg;
    logic [ptb_pkg::TICK_W-1:0]     ticks_reg;
    logic                           live_reg;

    logic [NUM_SLOTS-1:0]           valid_reg;
    logic [NUM_SLOTS-1:0]           valid_next;

    logic [IDX_W-1:0]               idx_reg;
    logic [IDX_W-1:0]               stage_idx_reg;
    logic                           stage_v_reg;
    logic [ptb_pkg::MASK_W-1:0]     fired_reg;
    logic [ptb_pkg::MASK_W-1:0]     fired_next;

    logic signed [DW-1:0]           period_mem [NUM_SLOTS];
    logic signed [DW-1:0]           count_mem  [NUM_SLOTS];
    logic signed [DW-1:0]           period_rd_reg;
    logic signed [DW-1:0]           count_rd_reg;

    logic                           out_valid_reg;
    logic [ptb_pkg::MASK_W-1:0]     fired_out_reg;
    logic signed [DW-1:0]           remaining_reg;
    logic                           missing_reg;

    logic                           in_inside;
    logic                           reg_inside;
    logic [IDX_W-1:0]               in_idx;
    logic [IDX_W-1:0]               reg_idx;
    logic [IDX_W-1:0]               rd_idx;
    logic                           rd_en;

    logic                           period_we;
    logic                           count_we;
    logic [IDX_W-1:0]               wr_idx;
    logic signed [DW-1:0]           count_wdata;

    logic [DW:0]                    diff;
    logic signed [DW-1:0]           sub_sat;
    logic                           fires;
    logic signed [DW-1:0]           tick_count;
    logic                           tick_wb;

    assign in_inside  = {{(ptb_pkg::SLOT_CMP_W - ptb_pkg::SLOT_W){1'b0}}, slot} < SLOT_LIMIT;
    assign reg_inside = {{(ptb_pkg::SLOT_CMP_W - ptb_pkg::SLOT_W){1'b0}}, slot_reg} < SLOT_LIMIT;
    assign in_idx     = IDX_W'(slot);
    assign reg_idx    = IDX_W'(slot_reg);
    assign rd_idx     = cmd.tick_issue ? idx_reg : reg_idx;
    assign rd_en      = cmd.tick_issue | cmd.slot_op;

    // countdown update for the slot in the read stage
    assign diff    = {count_rd_reg[DW-1], count_rd_reg}
                   - {{(DW + 1 - ptb_pkg::TICK_W){1'b0}}, ticks_reg};
    assign sub_sat = (diff[DW:DW-1] == 2'b10) ? ptb_pkg::VAL_MIN : diff[DW-1:0];
    assign fires   = sub_sat[DW-1] | (sub_sat == '0);
    assign tick_count = fires ? DW'(sub_sat + period_rd_reg) : sub_sat;
    assign tick_wb = stage_v_reg & valid_reg[stage_idx_reg] & ~period_rd_reg[DW-1];

    always_comb
    begin
        valid_next  = valid_reg;
        period_we   = 1'b0;
        count_we    = 1'b0;
        wr_idx      = reg_idx;
        count_wdata = period_reg;
        fired_next  = fired_reg;
        if (cmd.slot_op)
        begin
            case (kind_reg)
                ptb_pkg::KIND_CREATE:
                begin
                    if (reg_inside)
                    begin
                        valid_next[reg_idx] = 1'b1;
                        period_we           = 1'b1;
                        count_we            = 1'b1;
                    end
                end
                ptb_pkg::KIND_REMOVE:
                begin
                    if (live_reg)
                    begin
                        valid_next[reg_idx] = 1'b0;
                    end
                end
                ptb_pkg::KIND_SET_RESTART:
                begin
                    period_we = live_reg;
                    count_we  = live_reg;
                end
                ptb_pkg::KIND_SET_KEEP:
                begin
                    period_we = live_reg;
                end
                default:
                begin
                    period_we = 1'b0;
                end
            endcase
        end
        else if (tick_wb)
        begin
            count_we    = 1'b1;
            wr_idx      = stage_idx_reg;
            count_wdata = tick_count;
            if (fires && (32'(stage_idx_reg) < 32'(ptb_pkg::MASK_W)))
            begin
                fired_next[ptb_pkg::MASK_IDX_W'(stage_idx_reg)] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (period_we)
        begin
            period_mem[wr_idx] <= period_reg;
        end
        if (count_we)
        begin
            count_mem[wr_idx] <= count_wdata;
        end
        if (rd_en)
        begin
            period_rd_reg <= period_mem[rd_idx];
            count_rd_reg  <= count_mem[rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg   <= ptb_pkg::kind_t'(kind);
            slot_reg   <= slot;
            period_reg <= period;
            ticks_reg  <= tick_cycles;
            live_reg   <= in_inside & valid_reg[in_idx];
            idx_reg    <= '0;
            fired_reg  <= '0;
        end
        else
        begin
            fired_reg <= fired_next;
            if (cmd.tick_issue)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
        stage_idx_reg <= idx_reg;
        if (cmd.finish)
        begin
            fired_out_reg <= fired_reg;
            missing_reg   <= (kind_reg inside {ptb_pkg::KIND_REMOVE, ptb_pkg::KIND_READ})
                             & ~live_reg;
            if (kind_reg == ptb_pkg::KIND_READ)
            begin
                remaining_reg <= live_reg ? count_rd_reg : ptb_pkg::REMAINING_MISSING;
            end
            else
            begin
                remaining_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            stage_v_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            stage_v_reg <= cmd.tick_issue;
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.last_idx = (idx_reg == LAST_IDX);
    assign status.out_free = ~out_valid_reg | ~out_stall;

    assign out_valid    = out_valid_reg;
    assign fired_mask   = fired_out_reg;
    assign remaining    = remaining_reg;
    assign missing_slot = missing_reg;

endmodule

// ----- rtl/core/periodic_timer_bank.sv -----
// Bank of NUM_SLOTS periodic countdown timers. Each transaction carries a kind (tick, create,
// remove, set with restart, set keeping the countdown, read) and returns exactly one result
// holding the fired mask, the remaining count of a read and a missing-slot flag. A tick walks
// the slots one per cycle through the single read and write port of the period and countdown
// memories in ST_TICK, then passes through ST_DRAIN and ST_FINISH before the block takes the
// next transaction; every other kind passes through ST_SLOT and ST_FINISH. The input side
// stalls while a transaction is in progress; a finished result sits in an output register, so
// the next transaction is taken while the downstream side still stalls on it. Slots at or
// above eight cannot be addressed, so they are never created and have no bit in fired_mask.
`include "periodic_timer_bank_assert.svh"

module periodic_timer_bank
#(
    parameter int NUM_SLOTS = ptb_pkg::NUM_SLOTS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ptb_pkg::KIND_W-1:0]          kind,
    input  logic [ptb_pkg::SLOT_W-1:0]          slot,
    input  logic signed [ptb_pkg::DATA_W-1:0]   period,
    input  logic [ptb_pkg::TICK_W-1:0]          tick_cycles,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ptb_pkg::MASK_W-1:0]          fired_mask,
    output logic signed [ptb_pkg::DATA_W-1:0]   remaining,
    output logic                                missing_slot
);

    ptb_pkg::cmd_t    ctrl_cmd;
    ptb_pkg::status_t dp_status;

    ptb_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .in_stall (in_stall),
        .status   (dp_status),
        .cmd      (ctrl_cmd)
    );

    ptb_datapath
    #(
        .NUM_SLOTS (NUM_SLOTS)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (ctrl_cmd),
        .status       (dp_status),
        .kind         (kind),
        .slot         (slot),
        .period       (period),
        .tick_cycles  (tick_cycles),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .fired_mask   (fired_mask),
        .remaining    (remaining),
        .missing_slot (missing_slot)
    );

    // busy after every accepted transaction
    `PTB_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    // a loaded result shows up at the output
    `PTB_ASSERT_NEXT(a_finish_loads_output, ctrl_cmd.finish, out_valid)
    // fire bits only come from ticks, which never report a count or a miss
    `PTB_ASSERT_SAME(a_fired_is_tick_only, out_valid && (fired_mask != '0),
                     (remaining == '0) && !missing_slot)
    // a nonzero count on a miss can only be the read miss marker
    `PTB_ASSERT_SAME(a_missing_read_marker, out_valid && missing_slot && (remaining != '0),
                     remaining == ptb_pkg::REMAINING_MISSING)

endmodule
